@@ rtl/core/usd_pkg.sv @@
// usd_pkg: shared types, constants and helpers for the utf-8 stream decoder
// no dependencies; used by usd_step and utf8_stream_decoder

package usd_pkg;

   localparam int unsigned CP_WIDTH  = 21;
   localparam int unsigned MAX_RSP   = 4;
   localparam int unsigned HELD_MAX  = 3;

   localparam logic [CP_WIDTH-1:0] ESC_BASE = 21'h00DC00;
   localparam logic [12:0]         ESC_HIGH = ESC_BASE[20:8];

   localparam logic [7:0] ASCII_LIMIT = 8'h80;
   localparam logic [7:0] LEAD_MIN    = 8'hC2;
   localparam logic [7:0] LEAD3_MIN   = 8'hE0;
   localparam logic [7:0] LEAD4_MIN   = 8'hF0;
   localparam logic [7:0] LEAD_LIMIT  = 8'hF5;
   localparam logic [7:0] LEAD_E0     = 8'hE0;
   localparam logic [7:0] LEAD_F0     = 8'hF0;
   localparam logic [7:0] LEAD_F4     = 8'hF4;
   localparam logic [7:0] E0_CONT_MIN = 8'hA0;
   localparam logic [7:0] F0_CONT_MIN = 8'h90;
   localparam logic [7:0] F4_CONT_LIM = 8'h90;

   localparam logic [2:0] SEQ_LEN2 = 3'd2;
   localparam logic [2:0] SEQ_LEN3 = 3'd3;
   localparam logic [2:0] SEQ_LEN4 = 3'd4;

   typedef struct packed {
      logic [CP_WIDTH-1:0] code_point;
      logic                escaped;
   } result_type;

   typedef struct packed {
      logic [HELD_MAX-1:0][7:0] held;
      logic [1:0]               count;
      logic [2:0]               seq_len;
   } dec_state_type;

   function automatic result_type usd_escape(input logic [7:0] raw);
      result_type r;
      r.code_point = ESC_BASE | CP_WIDTH'(raw);
      r.escaped    = 1'b1;
      return r;
   endfunction

endpackage

@@ rtl/core/usd_step.sv @@
// usd_step: next-state and result list for one input byte of the decoder
// depends on usd_pkg

module usd_step (
   input  usd_pkg::dec_state_type state_ff,
   input  logic [7:0]             in_byte,
   input  logic                   eot,
   output usd_pkg::dec_state_type state_in,
   output usd_pkg::result_type    results [usd_pkg::MAX_RSP],
   output logic [2:0]             rsp_count
);

   logic                is_ascii;
   logic                is_lead;
   logic                fresh_emit;
   usd_pkg::result_type fresh_res;
   logic [2:0]          lead_len;
   logic                is_open;
   logic                cont_ok;
   logic                bad_second;
   logic                ok;
   logic                complete;
   logic [1:0]          nflush;
   logic                tail_v;
   usd_pkg::result_type tail;
   usd_pkg::result_type assembled;

   always_comb begin
      is_ascii   = in_byte < usd_pkg::ASCII_LIMIT;
      is_lead    = (in_byte >= usd_pkg::LEAD_MIN) && (in_byte < usd_pkg::LEAD_LIMIT);
      fresh_emit = !is_lead || eot;
      if (is_ascii) begin
         fresh_res.code_point = usd_pkg::CP_WIDTH'(in_byte);
         fresh_res.escaped    = 1'b0;
      end else begin
         fresh_res = usd_pkg::usd_escape(in_byte);
      end
      if (in_byte < usd_pkg::LEAD3_MIN) begin
         lead_len = usd_pkg::SEQ_LEN2;
      end else if (in_byte < usd_pkg::LEAD4_MIN) begin
         lead_len = usd_pkg::SEQ_LEN3;
      end else begin
         lead_len = usd_pkg::SEQ_LEN4;
      end

      is_open    = state_ff.count != 2'd0;
      cont_ok    = in_byte[7:6] == 2'b10;
      bad_second = (state_ff.count == 2'd1) &&
                   (((state_ff.held[0] == usd_pkg::LEAD_E0) && (in_byte < usd_pkg::E0_CONT_MIN)) ||
                    ((state_ff.held[0] == usd_pkg::LEAD_F0) && (in_byte < usd_pkg::F0_CONT_MIN)) ||
                    ((state_ff.held[0] == usd_pkg::LEAD_F4) && (in_byte >= usd_pkg::F4_CONT_LIM)));
      ok         = cont_ok && !bad_second;
      complete   = ok && (({1'b0, state_ff.count} + 3'd1) == state_ff.seq_len);

      unique case (state_ff.seq_len)
         usd_pkg::SEQ_LEN2:
            assembled.code_point = {10'd0, state_ff.held[0][4:0], in_byte[5:0]};
         usd_pkg::SEQ_LEN3:
            assembled.code_point = {5'd0, state_ff.held[0][3:0], state_ff.held[1][5:0],
                                    in_byte[5:0]};
         default:
            assembled.code_point = {state_ff.held[0][2:0], state_ff.held[1][5:0],
                                    state_ff.held[2][5:0], in_byte[5:0]};
      endcase
      assembled.escaped = 1'b0;

      state_in = state_ff;
      nflush   = 2'd0;
      tail_v   = 1'b0;
      tail     = fresh_res;

      if (!is_open || !ok) begin
         // fresh decode, after flushing the held bytes on a bad byte
         if (is_open) begin
            nflush = state_ff.count;
         end
         tail_v = fresh_emit;
         tail   = fresh_res;
         if (is_lead && !eot) begin
            state_in.held[0] = in_byte;
            state_in.count   = 2'd1;
            state_in.seq_len = lead_len;
         end else begin
            state_in.count   = 2'd0;
            state_in.seq_len = 3'd0;
         end
      end else if (complete) begin
         tail_v           = 1'b1;
         tail             = assembled;
         state_in.count   = 2'd0;
         state_in.seq_len = 3'd0;
      end else if (eot) begin
         // truncated at end of text: held bytes and this one become escapes
         nflush           = state_ff.count;
         tail_v           = 1'b1;
         tail             = usd_pkg::usd_escape(in_byte);
         state_in.count   = 2'd0;
         state_in.seq_len = 3'd0;
      end else begin
         state_in.held[state_ff.count] = in_byte;
         state_in.count                = state_ff.count + 2'd1;
      end

      for (int i = 0; i < usd_pkg::HELD_MAX; i++) begin
         if (2'(i) < nflush) begin
            results[i] = usd_pkg::usd_escape(state_ff.held[i]);
         end else begin
            results[i] = tail;
         end
      end
      results[usd_pkg::MAX_RSP-1] = tail;
      rsp_count = {1'b0, nflush} + {2'd0, tail_v};
   end

endmodule

@@ rtl/core/utf8_stream_decoder.sv @@
// utf8_stream_decoder: streaming utf-8 decoder with escapes for invalid bytes
// depends on usd_pkg and usd_step
//
// One request carries one byte of text and an end-of-text flag; each request gives zero to
// four responses. The byte is decoded in the cycle it is accepted and its responses are
// written to a four-entry response buffer that drains one response per cycle while the
// receiver is ready. A request that gives at most one response lets the next request in
// as that response is taken, so the block takes one byte per cycle when not stalled; a
// request giving n responses (an error replay or end-of-text flush) holds off the next
// request while the buffer drains. The first response appears the cycle after acceptance.

module utf8_stream_decoder (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [7:0]                    req_in_byte,
   input  logic                          req_end_of_text,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [usd_pkg::CP_WIDTH-1:0]  rsp_code_point,
   output logic                          rsp_escaped,
   output logic                          rsp_run_last
);

   usd_pkg::dec_state_type state_ff;
   usd_pkg::dec_state_type state_in;
   usd_pkg::result_type    buf_ff [usd_pkg::MAX_RSP];
   usd_pkg::result_type    buf_in [usd_pkg::MAX_RSP];
   logic [2:0]             pend_ff;
   logic [1:0]             idx_ff;
   logic [2:0]             step_count;
   logic                   req_fire;
   logic                   rsp_fire;

   usd_step u_step (
      .state_ff  (state_ff),
      .in_byte   (req_in_byte),
      .eot       (req_end_of_text),
      .state_in  (state_in),
      .results   (buf_in),
      .rsp_count (step_count)
   );

   assign rsp_valid      = pend_ff != 3'd0;
   assign rsp_code_point = buf_ff[idx_ff].code_point;
   assign rsp_escaped    = buf_ff[idx_ff].escaped;
   assign rsp_run_last   = pend_ff == 3'd1;
   assign rsp_fire       = rsp_valid && rsp_ready;
   assign req_ready      = (pend_ff == 3'd0) || ((pend_ff == 3'd1) && rsp_ready);
   assign req_fire       = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
         pend_ff  <= 3'd0;
         idx_ff   <= 2'd0;
      end else if (req_fire) begin
         state_ff <= state_in;
         pend_ff  <= step_count;
         idx_ff   <= 2'd0;
      end else if (rsp_fire) begin
         pend_ff  <= pend_ff - 3'd1;
         idx_ff   <= idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         buf_ff <= buf_in;
      end
   end

   a_ascii_passes: assert property (@(posedge clock) disable iff (reset)
      (req_fire && (state_ff.count == 2'd0) && !req_in_byte[7]) |=>
      (rsp_valid && !rsp_escaped && rsp_run_last &&
       (rsp_code_point == usd_pkg::CP_WIDTH'($past(req_in_byte)))))
      else $error("ascii byte not passed straight through");

   a_open_len: assert property (@(posedge clock) disable iff (reset)
      (state_ff.count != 2'd0) |-> ({1'b0, state_ff.count} < state_ff.seq_len))
      else $error("held byte count reached sequence length");

   a_escape_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_escaped) |-> (rsp_code_point[20:8] == usd_pkg::ESC_HIGH))
      else $error("escape value outside escape range");

endmodule

@@ sim/tb_utf8_stream_decoder.sv @@
`timescale 1ns / 1ps
// tb_utf8_stream_decoder: self-checking bench for the utf-8 stream decoder
// a directed byte table and random text go in through valid/ready with random stalls;
// every response is checked against a built-in decoder; depends on usd_pkg, utf8_stream_decoder

module tb_utf8_stream_decoder;

   localparam int DIRECTED_ROWS = 25;
   localparam int RANDOM_BYTES  = 355;
   localparam int QUIET_TAIL    = 60;
   localparam int HOLD_AT       = 200;
   localparam int LONG_HOLD     = 60;
   localparam int STUCK_LIMIT   = 2000;
   localparam int SETTLE        = 16;
   localparam int MAX_PRINTS    = 100;

   localparam logic MID   = 1'b0;
   localparam logic LAST  = 1'b1;
   localparam logic PRED  = 1'b0;
   localparam logic FIXED = 1'b1;
   localparam logic RAW   = 1'b0;
   localparam logic ESC   = 1'b1;

   typedef struct packed {
      logic [7:0]                   text_byte;
      logic                         end_of_text;
      logic                         typed;
      logic [usd_pkg::CP_WIDTH-1:0] code_point;
      logic                         escaped;
   } stim_row_type;

   typedef struct {
      logic [usd_pkg::CP_WIDTH-1:0] code_point;
      logic                         escaped;
      logic                         run_last;
   } decoded_char_type;

   localparam stim_row_type DIRECTED_TEXT [0:DIRECTED_ROWS-1] = '{
      {8'h00, MID,  FIXED, 21'h000000, RAW},
      {8'h7F, MID,  FIXED, 21'h00007F, RAW},
      {8'h80, MID,  FIXED, 21'h00DC80, ESC},
      {8'hC1, MID,  FIXED, 21'h00DCC1, ESC},
      {8'hF5, MID,  FIXED, 21'h00DCF5, ESC},
      {8'hFF, LAST, FIXED, 21'h00DCFF, ESC},
      // smallest two-byte
      {8'hC2, MID,  PRED,  21'h0, RAW},
      {8'h80, MID,  PRED,  21'h0, RAW},
      // e0 overlong
      {8'hE0, MID,  PRED,  21'h0, RAW},
      {8'h9F, MID,  PRED,  21'h0, RAW},
      // surrogate passes through
      {8'hED, MID,  PRED,  21'h0, RAW},
      {8'hA0, MID,  PRED,  21'h0, RAW},
      {8'h80, MID,  PRED,  21'h0, RAW},
      // f0 overlong
      {8'hF0, MID,  PRED,  21'h0, RAW},
      {8'h8F, MID,  PRED,  21'h0, RAW},
      // f4 above the code space
      {8'hF4, MID,  PRED,  21'h0, RAW},
      {8'h90, MID,  PRED,  21'h0, RAW},
      // largest code point
      {8'hF4, MID,  PRED,  21'h0, RAW},
      {8'h8F, MID,  PRED,  21'h0, RAW},
      {8'hBF, MID,  PRED,  21'h0, RAW},
      {8'hBF, MID,  PRED,  21'h0, RAW},
      // truncated four-byte, new lead, then end of text: four responses
      {8'hF3, MID,  PRED,  21'h0, RAW},
      {8'h80, MID,  PRED,  21'h0, RAW},
      {8'h80, MID,  PRED,  21'h0, RAW},
      {8'hC2, LAST, PRED,  21'h0, RAW}
   };

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         req_valid = 1'b0;
   logic                         req_ready;
   logic [7:0]                   req_in_byte = 8'h00;
   logic                         req_end_of_text = 1'b0;
   logic                         rsp_valid;
   logic                         rsp_ready = 1'b0;
   logic [usd_pkg::CP_WIDTH-1:0] rsp_code_point;
   logic                         rsp_escaped;
   logic                         rsp_run_last;

   stim_row_type     text_q[$];
   stim_row_type     cur_text;
   decoded_char_type expected_chars[$];

   logic [7:0] open_bytes [0:2];
   int         open_count = 0;
   int         open_length = 0;

   int  mismatches = 0;
   int  bytes_taken = 0;
   int  text_ends = 0;
   int  chars_checked = 0;
   int  escapes_checked = 0;
   int  long_holds = 0;
   int  stuck_cycles = 0;
   bit  long_hold_req = 1'b0;
   bit  quiet_tail = 1'b0;

   utf8_stream_decoder i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_in_byte     (req_in_byte),
      .req_end_of_text (req_end_of_text),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_code_point  (rsp_code_point),
      .rsp_escaped     (rsp_escaped),
      .rsp_run_last    (rsp_run_last)
   );

   always #6 clock = ~clock;

   task automatic flag_mismatch(input string what, input int got, input int want);
      if (mismatches < MAX_PRINTS) begin
         $display("mismatch on %s: got %h, expected %h", what, got, want);
      end
      mismatches++;
   endtask

   // decoder predictor

   function automatic void note_char(input logic [usd_pkg::CP_WIDTH-1:0] cp,
                                     input logic esc);
      decoded_char_type d;
      d.code_point = cp;
      d.escaped    = esc;
      d.run_last   = 1'b0;
      expected_chars.push_back(d);
   endfunction

   function automatic void note_escape(input logic [7:0] raw);
      note_char(usd_pkg::ESC_BASE + usd_pkg::CP_WIDTH'(raw), 1'b1);
   endfunction

   function automatic void flush_open();
      for (int i = 0; i < open_count; i++) begin
         note_escape(open_bytes[i]);
      end
      open_count  = 0;
      open_length = 0;
   endfunction

   function automatic void start_fresh(input logic [7:0] b);
      if (b < usd_pkg::ASCII_LIMIT) begin
         note_char(usd_pkg::CP_WIDTH'(b), 1'b0);
      end else if (b < usd_pkg::LEAD_MIN || b >= usd_pkg::LEAD_LIMIT) begin
         note_escape(b);
      end else begin
         open_bytes[0] = b;
         open_count    = 1;
         if (b < usd_pkg::LEAD3_MIN) open_length = 2;
         else if (b < usd_pkg::LEAD4_MIN) open_length = 3;
         else open_length = 4;
      end
   endfunction

   function automatic logic [usd_pkg::CP_WIDTH-1:0] join_bits(input logic [7:0] b);
      logic [usd_pkg::CP_WIDTH-1:0] cp;
      case (open_length)
         2: cp = usd_pkg::CP_WIDTH'({open_bytes[0][4:0], b[5:0]});
         3: cp = usd_pkg::CP_WIDTH'({open_bytes[0][3:0], open_bytes[1][5:0], b[5:0]});
         default: cp = {open_bytes[0][2:0], open_bytes[1][5:0], open_bytes[2][5:0], b[5:0]};
      endcase
      return cp;
   endfunction

   function automatic void decode_text_byte(input logic [7:0] b, input logic eot);
      int               base;
      bit               good;
      decoded_char_type d;
      base = expected_chars.size();
      if (open_count == 0) begin
         start_fresh(b);
      end else begin
         good = (b[7:6] == 2'b10);
         if (good && open_count == 1) begin
            if (open_bytes[0] == usd_pkg::LEAD_E0 && b < usd_pkg::E0_CONT_MIN) good = 1'b0;
            if (open_bytes[0] == usd_pkg::LEAD_F0 && b < usd_pkg::F0_CONT_MIN) good = 1'b0;
            if (open_bytes[0] == usd_pkg::LEAD_F4 && b >= usd_pkg::F4_CONT_LIM) good = 1'b0;
         end
         if (!good) begin
            flush_open();
            start_fresh(b);
         end else if (open_count + 1 == open_length) begin
            note_char(join_bits(b), 1'b0);
            open_count  = 0;
            open_length = 0;
         end else begin
            open_bytes[open_count] = b;
            open_count++;
         end
      end
      if (eot && open_count != 0) flush_open();
      if (expected_chars.size() > base) begin
         d = expected_chars.pop_back();
         d.run_last = 1'b1;
         expected_chars.push_back(d);
      end
   endfunction

   function automatic void take_text_byte(input stim_row_type row);
      int               base;
      decoded_char_type d;
      base = expected_chars.size();
      decode_text_byte(row.text_byte, row.end_of_text);
      if (row.typed) begin
         while (expected_chars.size() > base) void'(expected_chars.pop_back());
         d.code_point = row.code_point;
         d.escaped    = row.escaped;
         d.run_last   = 1'b1;
         expected_chars.push_back(d);
      end
   endfunction

   // stimulus text

   function automatic void push_text(input logic [7:0] b, input logic eot);
      stim_row_type row;
      row = '0;
      row.text_byte   = b;
      row.end_of_text = eot;
      text_q.push_back(row);
   endfunction

   function automatic logic [7:0] any_cont();
      return {2'b10, 6'($urandom)};
   endfunction

   function automatic void build_text();
      int                           kind;
      int                           len;
      int                           conts;
      bit                           trunc;
      logic [usd_pkg::CP_WIDTH-1:0] cp;
      logic [7:0]                   lead;
      for (int i = 0; i < DIRECTED_ROWS; i++) text_q.push_back(DIRECTED_TEXT[i]);
      while (text_q.size() < DIRECTED_ROWS + RANDOM_BYTES) begin
         kind = $urandom_range(0, 99);
         if (kind < 60) begin
            len = $urandom_range(1, 4);
            case (len)
               1: begin
                  cp = usd_pkg::CP_WIDTH'($urandom_range(0, 'h7F));
                  push_text(cp[7:0], $urandom_range(0, 19) == 0);
               end
               2: begin
                  cp = usd_pkg::CP_WIDTH'($urandom_range('h80, 'h7FF));
                  push_text({3'b110, cp[10:6]}, MID);
                  push_text({2'b10, cp[5:0]}, $urandom_range(0, 19) == 0);
               end
               3: begin
                  cp = usd_pkg::CP_WIDTH'($urandom_range('h800, 'hFFFF));
                  push_text({4'b1110, cp[15:12]}, MID);
                  push_text({2'b10, cp[11:6]}, MID);
                  push_text({2'b10, cp[5:0]}, $urandom_range(0, 19) == 0);
               end
               default: begin
                  cp = usd_pkg::CP_WIDTH'($urandom_range('h10000, 'h10FFFF));
                  push_text({5'b11110, cp[20:18]}, MID);
                  push_text({2'b10, cp[17:12]}, MID);
                  push_text({2'b10, cp[11:6]}, MID);
                  push_text({2'b10, cp[5:0]}, $urandom_range(0, 19) == 0);
               end
            endcase
         end else if (kind < 85) begin
            case ($urandom_range(0, 5))
               0: lead = usd_pkg::LEAD_E0;
               1: lead = usd_pkg::LEAD_F0;
               2: lead = usd_pkg::LEAD_F4;
               default: lead = 8'($urandom_range(usd_pkg::LEAD_MIN, usd_pkg::LEAD_LIMIT - 1));
            endcase
            if (lead < usd_pkg::LEAD3_MIN) len = 2;
            else if (lead < usd_pkg::LEAD4_MIN) len = 3;
            else len = 4;
            conts = $urandom_range(0, len - 2);
            trunc = $urandom_range(0, 2) == 0;
            push_text(lead, trunc && conts == 0);
            for (int j = 0; j < conts; j++) push_text(any_cont(), trunc && j == conts - 1);
            if (!trunc) push_text(8'($urandom_range(0, 255)), $urandom_range(0, 19) == 0);
         end else begin
            push_text(8'($urandom_range(0, 255)), $urandom_range(0, 19) == 0);
         end
      end
   endfunction

   // sender, end of run

   initial begin : drive_text
      int gap;
      build_text();
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      for (int i = 0; i < text_q.size(); i++) begin
         if (i >= text_q.size() - QUIET_TAIL) quiet_tail = 1'b1;
         if (!quiet_tail && $urandom_range(0, 5) == 0) begin
            req_valid <= 1'b0;
            gap = $urandom_range(1, 4);
            repeat (gap) @(negedge clock);
         end
         if (i == HOLD_AT) long_hold_req = 1'b1;
         cur_text = text_q[i];
         req_valid       <= 1'b1;
         req_in_byte     <= text_q[i].text_byte;
         req_end_of_text <= text_q[i].end_of_text;
         @(posedge clock);
         while (!(req_valid && req_ready)) @(posedge clock);
         @(negedge clock);
      end
      req_valid <= 1'b0;
      while (expected_chars.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      if (expected_chars.size() != 0) flag_mismatch("responses left over", 0,
                                                    expected_chars.size());
      $display("sent %0d bytes (%0d from the directed table), %0d of them ending a text",
               bytes_taken, DIRECTED_ROWS, text_ends);
      $display("checked %0d responses (%0d escapes), %0d long receiver hold-offs, %0d mismatches",
               chars_checked, escapes_checked, long_holds, mismatches);
      if (mismatches == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   // receiver

   initial begin : take_responses
      int gap;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (long_hold_req) begin
            long_hold_req = 1'b0;
            long_holds++;
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD) @(negedge clock);
            rsp_ready <= 1'b1;
         end else if (!quiet_tail && $urandom_range(0, 4) == 0) begin
            rsp_ready <= 1'b0;
            gap = $urandom_range(1, 4);
            repeat (gap) @(negedge clock);
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= 1'b1;
         end
         @(negedge clock);
      end
   end

   // checker

   always @(posedge clock) begin : check_responses
      decoded_char_type want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            chars_checked++;
            if (rsp_escaped) escapes_checked++;
            if (expected_chars.size() == 0) begin
               flag_mismatch("unexpected response, code point", int'(rsp_code_point), 0);
            end else begin
               want = expected_chars.pop_front();
               if (rsp_code_point !== want.code_point)
                  flag_mismatch("code_point", int'(rsp_code_point), int'(want.code_point));
               if (rsp_escaped !== want.escaped)
                  flag_mismatch("escaped", int'(rsp_escaped), int'(want.escaped));
               if (rsp_run_last !== want.run_last)
                  flag_mismatch("run_last", int'(rsp_run_last), int'(want.run_last));
            end
         end
         if (req_valid && req_ready) begin
            bytes_taken++;
            if (cur_text.end_of_text) text_ends++;
            take_text_byte(cur_text);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stuck_cycles <= 0;
      end else if (stuck_cycles == STUCK_LIMIT) begin
         $display("no request or response moved for %0d cycles", STUCK_LIMIT);
         $display("FAILURE");
         $finish;
      end else begin
         stuck_cycles <= stuck_cycles + 1;
      end
   end

endmodule
